// ===== sv/kfip_pkg.sv =====
`timescale 1ns / 1ps
package kfip_pkg;

  // Sizes
  localparam int RoundCount = 8;
  localparam int IndexBits  = 32;
  localparam int KeyBits    = 64;
  localparam int SizeBits   = IndexBits + 1;
  localparam int RoundIdxW  = (RoundCount > 1) ? $clog2(RoundCount) : 1;
  localparam int WidthBits  = $clog2(IndexBits + 1);
  localparam int StepBits   = 4;
  localparam int CfgAddrBits = 1;

  localparam logic [RoundIdxW-1:0] RndLast = RoundIdxW'(RoundCount - 1);

  // Mixing constants
  localparam logic [KeyBits-1:0] GoldenStep    = 64'h9e3779b97f4a7c15;
  localparam logic [KeyBits-1:0] MixMulA       = 64'hbf58476d1ce4e5b9;
  localparam logic [KeyBits-1:0] MixMulB       = 64'h94d049bb133111eb;
  localparam logic [KeyBits-1:0] PermDomainTag = 64'h9f6abc142d337e51;
  localparam int MixShiftPre = 30;
  localparam int MixShiftMid = 27;
  localparam int MixShiftEnd = 31;

  // Configuration register indexes
  localparam logic [CfgAddrBits-1:0] CfgCarrierKey = 1'd0;
  localparam logic [CfgAddrBits-1:0] CfgDomainSize = 1'd1;

  // Steps of one mix evaluation on the shared 32x32 multiplier
  typedef enum logic [StepBits-1:0] {
    MsPre      = 4'd0,
    MsMulLoA   = 4'd1,
    MsMulHiA   = 4'd2,
    MsMulCrsA  = 4'd3,
    MsMid      = 4'd4,
    MsMulLoB   = 4'd5,
    MsMulHiB   = 4'd6,
    MsMulCrsB  = 4'd7,
    MsEnd      = 4'd8
  } mix_step_e;

  // Datapath operations
  typedef enum logic [2:0] {
    OpNone = 3'd0,
    OpPre  = 3'd1,
    OpMul0 = 3'd2,
    OpMul1 = 3'd3,
    OpMul2 = 3'd4,
    OpMid  = 3'd5,
    OpEnd  = 3'd6
  } dp_op_e;

  typedef struct packed {
    dp_op_e                op;
    logic                  mul_b;
    logic                  key_mode;
    logic [RoundIdxW-1:0]  rnd;
    logic                  setup_start;
    logic                  load_in;
    logic                  check;
    logic                  out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic in_oor;
    logic span_zero;
    logic walk_again;
  } dp_status_t;

endpackage

// ===== sv/kfip_ctrl.sv =====
`timescale 1ns / 1ps
module kfip_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  kfip_pkg::dp_status_t status_i,
  output kfip_pkg::dp_cmd_t    cmd_o
);

  typedef enum logic [6:0] {
    StStart = 7'b0000001,
    StSetup = 7'b0000010,
    StWait  = 7'b0000100,
    StIdle  = 7'b0001000,
    StRound = 7'b0010000,
    StCheck = 7'b0100000,
    StDone  = 7'b1000000
  } state_e;

  state_e                         state_q, state_d;
  kfip_pkg::mix_step_e            step_q, step_d;
  logic [kfip_pkg::RoundIdxW-1:0] rnd_q, rnd_d;
  logic                           out_valid_q, out_valid_d;

  kfip_pkg::dp_op_e step_op;
  logic             step_mul_b;
  logic             step_end;
  logic             rnd_last;

  // Map the mix step to a datapath operation
  always_comb begin
    step_op    = kfip_pkg::OpNone;
    step_mul_b = 1'b0;
    unique case (step_q)
      kfip_pkg::MsPre:     step_op = kfip_pkg::OpPre;
      kfip_pkg::MsMulLoA:  step_op = kfip_pkg::OpMul0;
      kfip_pkg::MsMulHiA:  step_op = kfip_pkg::OpMul1;
      kfip_pkg::MsMulCrsA: step_op = kfip_pkg::OpMul2;
      kfip_pkg::MsMid:     step_op = kfip_pkg::OpMid;
      kfip_pkg::MsMulLoB: begin
        step_op    = kfip_pkg::OpMul0;
        step_mul_b = 1'b1;
      end
      kfip_pkg::MsMulHiB: begin
        step_op    = kfip_pkg::OpMul1;
        step_mul_b = 1'b1;
      end
      kfip_pkg::MsMulCrsB: begin
        step_op    = kfip_pkg::OpMul2;
        step_mul_b = 1'b1;
      end
      kfip_pkg::MsEnd: begin
        step_op    = kfip_pkg::OpEnd;
        step_mul_b = 1'b1;
      end
      default: step_op = kfip_pkg::OpNone;
    endcase
  end

  assign step_end = (step_q == kfip_pkg::MsEnd);
  assign rnd_last = (rnd_q == kfip_pkg::RndLast);

  // Sequence setup, rounds, walk check and result handoff
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    rnd_d       = rnd_q;
    out_valid_d = out_valid_q && !out_ready_i;
    in_ready_o  = 1'b0;

    cmd_o             = '0;
    cmd_o.op          = kfip_pkg::OpNone;
    cmd_o.rnd         = rnd_q;

    unique case (state_q)
      StStart: begin
        cmd_o.setup_start = 1'b1;
        step_d            = kfip_pkg::MsPre;
        rnd_d             = '0;
        state_d           = StSetup;
      end
      StSetup, StRound: begin
        cmd_o.op       = step_op;
        cmd_o.mul_b    = step_mul_b;
        cmd_o.key_mode = (state_q == StSetup);
        if (step_end) begin
          step_d = kfip_pkg::MsPre;
          if (rnd_last) begin
            rnd_d   = '0;
            state_d = (state_q == StSetup) ? StWait : StCheck;
          end else begin
            rnd_d = rnd_q + 1'b1;
          end
        end else begin
          step_d = kfip_pkg::mix_step_e'(step_q + 1'b1);
        end
      end
      StWait: begin
        if (status_i.span_zero) begin
          state_d = StIdle;
        end
      end
      StIdle: begin
        in_ready_o = !cfg_we_i;
        if (in_valid_i && !cfg_we_i) begin
          cmd_o.load_in = 1'b1;
          step_d        = kfip_pkg::MsPre;
          rnd_d         = '0;
          state_d       = status_i.in_oor ? StDone : StRound;
        end
      end
      StCheck: begin
        cmd_o.check = 1'b1;
        state_d     = status_i.walk_again ? StRound : StDone;
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = StIdle;
        end
      end
      default: state_d = StStart;
    endcase

    // Restart setup on any configuration write
    if (cfg_we_i) begin
      state_d = StStart;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StStart;
      step_q      <= kfip_pkg::MsPre;
      rnd_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      rnd_q       <= rnd_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/kfip_dp.sv =====
`timescale 1ns / 1ps
module kfip_dp (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [kfip_pkg::CfgAddrBits-1:0]   cfg_addr_i,
  input  logic [kfip_pkg::KeyBits-1:0]       cfg_wdata_i,
  input  logic [kfip_pkg::IndexBits-1:0]     in_index_i,
  input  kfip_pkg::dp_cmd_t                  cmd_i,
  output kfip_pkg::dp_status_t               status_o,
  output logic [kfip_pkg::IndexBits-1:0]     position_o,
  output logic                               out_of_range_o
);

  localparam int Kb = kfip_pkg::KeyBits;
  localparam int Ib = kfip_pkg::IndexBits;
  localparam int Sb = kfip_pkg::SizeBits;
  localparam int Wb = kfip_pkg::WidthBits;
  localparam int Hb = Kb / 2;
  localparam logic [Sb-1:0] SizeMin = Sb'(2);
  localparam logic [Sb-1:0] SizeCap = {1'b1, {Ib{1'b0}}};

  function automatic logic [Ib-1:0] low_mask(input logic [Wb-1:0] w);
    return ~({Ib{1'b1}} << w);
  endfunction

  // Configuration registers
  logic [Kb-1:0] key_q;
  logic [Sb-1:0] size_q, size_wr;

  // Setup state
  logic [Kb-1:0] key_store_q [kfip_pkg::RoundCount];
  logic [Kb-1:0] gstep_q, gstep_d;
  logic [Ib-1:0] span_q, span_d;
  logic [Wb-1:0] bits_q, bits_d;
  logic [Wb-1:0] lw_base, rw_base;

  // Mix unit
  logic [Kb-1:0] mv_q, mv_d, prod_q, prod_d, acc_q, acc_d;
  logic [Kb-1:0] mix_in, pre_sum, pre_val, fin_sum, mid_val, round_f, mul_const;
  logic [Hb-1:0] mul_a, mul_b;
  logic [Kb-1:0] mul_p;

  // Feistel halves
  logic [Ib-1:0] left_q, left_d, right_q, right_d;
  logic [Wb-1:0] lw_cur_q, lw_cur_d, rw_cur_q, rw_cur_d;
  logic [Ib-1:0] v_comb, split_src;
  logic          oor_q, oor_d, in_oor, walk_again;
  logic [Ib-1:0] position_q, position_d;
  logic          out_oor_q, out_oor_d;
  logic          key_write;

  // Clamp a written domain size into range
  always_comb begin
    size_wr = cfg_wdata_i[Sb-1:0];
    if (size_wr < SizeMin) begin
      size_wr = SizeMin;
    end else if (size_wr > SizeCap) begin
      size_wr = SizeCap;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q  <= '0;
      size_q <= SizeMin;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        kfip_pkg::CfgCarrierKey: key_q  <= cfg_wdata_i;
        kfip_pkg::CfgDomainSize: size_q <= size_wr;
        default: key_q <= key_q;
      endcase
    end
  end

  // Half widths from the bit length of size minus one
  assign lw_base = bits_q >> 1;
  assign rw_base = bits_q - lw_base;

  always_comb begin
    span_d  = span_q;
    bits_d  = bits_q;
    gstep_d = gstep_q;
    if (cmd_i.setup_start) begin
      span_d  = Ib'(size_q - 1'b1);
      bits_d  = '0;
      gstep_d = '0;
    end else begin
      if (span_q != '0) begin
        span_d = span_q >> 1;
        bits_d = bits_q + 1'b1;
      end
      if (key_write) begin
        gstep_d = gstep_q + kfip_pkg::GoldenStep;
      end
    end
  end

  assign key_write = (cmd_i.op == kfip_pkg::OpEnd) && cmd_i.key_mode;

  // Mix datapath: add and xor-shift, then two 64-bit products from 32x32 parts
  assign mix_in = cmd_i.key_mode ? (key_q ^ kfip_pkg::PermDomainTag ^ gstep_q)
                                 : ({{(Kb - Ib){1'b0}}, right_q} ^ key_store_q[cmd_i.rnd]);
  assign pre_sum   = mix_in + kfip_pkg::GoldenStep;
  assign pre_val   = pre_sum ^ (pre_sum >> kfip_pkg::MixShiftPre);
  assign mul_const = cmd_i.mul_b ? kfip_pkg::MixMulB : kfip_pkg::MixMulA;
  assign mul_a     = (cmd_i.op == kfip_pkg::OpMul1) ? mv_q[Kb-1:Hb] : mv_q[Hb-1:0];
  assign mul_b     = (cmd_i.op == kfip_pkg::OpMul2) ? mul_const[Kb-1:Hb] : mul_const[Hb-1:0];
  assign mul_p     = mul_a * mul_b;
  assign fin_sum   = acc_q + {prod_q[Hb-1:0], {Hb{1'b0}}};
  assign mid_val   = fin_sum ^ (fin_sum >> kfip_pkg::MixShiftMid);
  assign round_f   = fin_sum ^ (fin_sum >> kfip_pkg::MixShiftEnd);

  always_comb begin
    mv_d   = mv_q;
    prod_d = prod_q;
    acc_d  = acc_q;
    unique case (cmd_i.op)
      kfip_pkg::OpPre: mv_d = pre_val;
      kfip_pkg::OpMul0: begin
        prod_d = mul_p;
        acc_d  = '0;
      end
      kfip_pkg::OpMul1: begin
        prod_d = mul_p;
        acc_d  = acc_q + prod_q;
      end
      kfip_pkg::OpMul2: begin
        prod_d = mul_p;
        acc_d  = acc_q + {prod_q[Hb-1:0], {Hb{1'b0}}};
      end
      kfip_pkg::OpMid: mv_d = mid_val;
      kfip_pkg::OpNone, kfip_pkg::OpEnd: mv_d = mv_q;
      default: mv_d = mv_q;
    endcase
  end

  // Recombine halves and compare for cycle walking
  assign v_comb     = (left_q << rw_cur_q) | right_q;
  assign walk_again = ({1'b0, v_comb} >= size_q);
  assign in_oor     = ({1'b0, in_index_i} >= size_q);
  assign split_src  = cmd_i.load_in ? in_index_i : v_comb;

  always_comb begin
    left_d     = left_q;
    right_d    = right_q;
    lw_cur_d   = lw_cur_q;
    rw_cur_d   = rw_cur_q;
    oor_d      = oor_q;
    position_d = position_q;
    out_oor_d  = out_oor_q;
    if (cmd_i.load_in) begin
      oor_d = in_oor;
    end
    // Split a fresh value into halves at the base widths
    if (cmd_i.load_in || (cmd_i.check && walk_again)) begin
      left_d   = split_src >> rw_base;
      right_d  = split_src & low_mask(rw_base);
      lw_cur_d = lw_base;
      rw_cur_d = rw_base;
    end else if ((cmd_i.op == kfip_pkg::OpEnd) && !cmd_i.key_mode) begin
      // Feistel round: swap halves and widths
      left_d   = right_q;
      right_d  = (left_q ^ round_f[Ib-1:0]) & low_mask(lw_cur_q);
      lw_cur_d = rw_cur_q;
      rw_cur_d = lw_cur_q;
    end
    if (cmd_i.out_load) begin
      position_d = oor_q ? '0 : v_comb;
      out_oor_d  = oor_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (key_write) begin
      key_store_q[cmd_i.rnd] <= round_f;
    end
    gstep_q    <= gstep_d;
    span_q     <= span_d;
    bits_q     <= bits_d;
    mv_q       <= mv_d;
    prod_q     <= prod_d;
    acc_q      <= acc_d;
    left_q     <= left_d;
    right_q    <= right_d;
    lw_cur_q   <= lw_cur_d;
    rw_cur_q   <= rw_cur_d;
    oor_q      <= oor_d;
    position_q <= position_d;
    out_oor_q  <= out_oor_d;
  end

  assign status_o.in_oor     = in_oor;
  assign status_o.span_zero  = (span_q == '0);
  assign status_o.walk_again = walk_again;
  assign position_o          = position_q;
  assign out_of_range_o      = out_oor_q;

endmodule

// ===== sv/keyed_feistel_index_permuter.sv =====
`timescale 1ns / 1ps
// An in-range index is permuted by Feistel passes, repeated by cycle walking until the value
// falls inside the domain; an out-of-range index skips the rounds and is flagged. Throughput:
// one item at a time, so the next index is taken only after the previous result has been
// loaded into the output register, which waits while a held result is not yet taken.
// Each round evaluates the mixer on one shared 32x32 multiplier (6 products).
// Reset and each register write run a key and width setup with input held off.
module keyed_feistel_index_permuter (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [kfip_pkg::CfgAddrBits-1:0] cfg_addr_i,
  input  logic [kfip_pkg::KeyBits-1:0]     cfg_wdata_i,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [kfip_pkg::IndexBits-1:0]   s_axis_tdata_i,   // [31:0] index
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [kfip_pkg::IndexBits-1:0]   m_axis_tdata_o,   // [31:0] position
  output logic [0:0]                       m_axis_tuser_o    // [0] out_of_range
);

  kfip_pkg::dp_cmd_t    cmd;
  kfip_pkg::dp_status_t status;

  kfip_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  kfip_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_index_i     (s_axis_tdata_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .position_o     (m_axis_tdata_o),
    .out_of_range_o (m_axis_tuser_o[0])
  );

endmodule

// ===== sv/kfip_checker.sv =====
`timescale 1ns / 1ps
module kfip_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [kfip_pkg::IndexBits-1:0] m_axis_tdata_o,
  input logic [0:0]                     m_axis_tuser_o
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // Flagged results carry a zero position
  a_flag_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o[0] |-> m_axis_tdata_o == '0)
    else $error("out-of-range result with nonzero position");

  // One transaction in work at a time
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second transaction accepted while busy");

endmodule

bind keyed_feistel_index_permuter kfip_checker u_kfip_checker (.*);
